// ===== rtl/core/ncdf_pkg.sv =====
// shared constants and types for the normal cdf pipeline
// used by ncdf_phi and normal_cdf_approx; no dependencies
package ncdf_pkg;

    // port widths
    localparam int IN_W      = 32;
    localparam int DATA_IN_W = 2 * IN_W;
    localparam int KIND_W    = 2;
    localparam int PROB_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_STD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SCALE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIFF  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEAN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 1'b1;

    localparam logic [CFG_W-1:0] MEAN_RST   = 32'd0;
    localparam logic [CFG_W-1:0] SPREAD_RST = 32'd65536;

    // standardizing divider: |x - mean| * 2^16 / spread, quotient kept to 20 bits
    localparam int FRAC_W   = 16;
    localparam int DIFF_W   = IN_W + 1;
    localparam int SPR_W    = CFG_W - 1;
    localparam int STD_BITS = 20;

    // |z| in unsigned Q16, clamped to 8.0
    localparam int T_W = 20;
    localparam logic [T_W-1:0] T_MAX = 20'h80000;

    // polynomial and reciprocal datapath
    localparam int HORNER_N = 6;
    localparam int ACC_W    = 30;
    localparam int PH_W     = ACC_W + T_W;
    localparam int Q_W      = 34;
    localparam int R_W      = 31;
    localparam int DIV_N    = R_W;
    localparam int SQ_N     = 4;
    localparam int SQ_W     = 2 * R_W;
    localparam logic [R_W-1:0] ONE_Q30 = 31'h4000_0000;

    // phi lane latency: horner, q, divider, squarings, final half
    localparam int PHI_LAT = HORNER_N + 1 + DIV_N + SQ_N + 1;

    // d1..d6 in Q30
    typedef logic [ACC_W-1:0] coef_arr_t [HORNER_N];
    localparam coef_arr_t COEF = '{
        30'd53544656, 30'd22699982, 30'd3519324, 30'd40806, 30'd52496, 30'd5780
    };

endpackage

// ===== rtl/core/ncdf_phi.sv =====
// one phi lane: clamped |z| in Q16 to the standard normal cdf in Q30
// pipelined horner, restoring reciprocal divider and four squarings; uses ncdf_pkg
module ncdf_phi (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [ncdf_pkg::T_W-1:0] t_in,
    input  logic                     pos_in,
    output logic [ncdf_pkg::R_W-1:0] phi_out
);
    import ncdf_pkg::*;

    function automatic logic [PH_W-17:0] rnd16(input logic [PH_W-1:0] p);
        logic [PH_W-1:0] s;
        s = p + PH_W'(32'd32768);
        return s[PH_W-1:16];
    endfunction

    function automatic logic [SQ_W-31:0] rnd30(input logic [SQ_W-1:0] p);
        logic [SQ_W-1:0] s;
        s = p + SQ_W'(ONE_Q30 >> 1);
        return s[SQ_W-1:30];
    endfunction

    // horner stages
    logic [T_W-1:0]   h_t_reg   [HORNER_N];
    logic             h_pos_reg [HORNER_N];
    logic [PH_W-1:0]  h_p_reg   [HORNER_N];
    logic [ACC_W-1:0] h_acc     [HORNER_N];

    // q = 1 + poly
    logic [Q_W-1:0] q_reg;
    logic           q_pos_reg;

    // reciprocal divider stages
    logic [Q_W-1:0] d_rem_reg [DIV_N];
    logic [R_W-1:0] d_quo_reg [DIV_N];
    logic [Q_W-1:0] d_q_reg   [DIV_N];
    logic           d_pos_reg [DIV_N];
    logic [Q_W-1:0] d_rin     [DIV_N];
    logic [Q_W-1:0] d_qin     [DIV_N];
    logic           d_posin   [DIV_N];
    logic [Q_W:0]   d_trial   [DIV_N];
    logic           d_ge      [DIV_N];
    logic [Q_W-1:0] d_rout    [DIV_N];
    logic [R_W-1:0] d_quo     [DIV_N];

    // squaring stages
    logic [SQ_W-1:0] s_p_reg   [SQ_N];
    logic            s_pos_reg [SQ_N];
    logic [R_W-1:0]  s_r       [SQ_N];

    logic [R_W-1:0] fin_r;
    logic [R_W:0]   fin_sum;
    logic [R_W-1:0] fin_half;
    logic [R_W-1:0] phi_reg;

    always_comb begin
        h_acc[0] = COEF[HORNER_N-1];
        for (int k = 1; k < HORNER_N; k++) begin
            h_acc[k] = COEF[HORNER_N-1-k] + ACC_W'(rnd16(h_p_reg[k-1]));
        end
    end

    // long division of 2^60 + q/2 by q, one quotient bit per stage
    always_comb begin
        for (int j = 0; j < DIV_N; j++) begin
            if (j == 0) begin
                d_rin[j]   = Q_W'(ONE_Q30 >> 1) + Q_W'(q_reg[Q_W-1:DIV_N+1]);
                d_qin[j]   = q_reg;
                d_posin[j] = q_pos_reg;
            end else begin
                d_rin[j]   = d_rem_reg[j-1];
                d_qin[j]   = d_q_reg[j-1];
                d_posin[j] = d_pos_reg[j-1];
            end
            // low numerator bits are q[31:1]
            d_trial[j] = {d_rin[j], d_qin[j][DIV_N-j]};
            d_ge[j]    = (d_trial[j] >= {1'b0, d_qin[j]});
            d_rout[j]  = d_ge[j] ? Q_W'(d_trial[j] - {1'b0, d_qin[j]}) : Q_W'(d_trial[j]);
            if (j == 0) begin
                d_quo[j] = R_W'(d_ge[j]);
            end else begin
                d_quo[j] = {d_quo_reg[j-1][R_W-2:0], d_ge[j]};
            end
        end
    end

    always_comb begin
        s_r[0] = d_quo_reg[DIV_N-1];
        for (int s = 1; s < SQ_N; s++) begin
            s_r[s] = R_W'(rnd30(s_p_reg[s-1]));
        end
        fin_r    = R_W'(rnd30(s_p_reg[SQ_N-1]));
        fin_sum  = {1'b0, fin_r} + (R_W+1)'(1);
        fin_half = fin_sum[R_W:1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_t_reg[0]   <= t_in;
            h_pos_reg[0] <= pos_in;
            h_p_reg[0]   <= PH_W'(h_acc[0]) * PH_W'(t_in);
            for (int k = 1; k < HORNER_N; k++) begin
                h_t_reg[k]   <= h_t_reg[k-1];
                h_pos_reg[k] <= h_pos_reg[k-1];
                h_p_reg[k]   <= PH_W'(h_acc[k]) * PH_W'(h_t_reg[k-1]);
            end
            q_reg     <= Q_W'(ONE_Q30) + Q_W'(rnd16(h_p_reg[HORNER_N-1]));
            q_pos_reg <= h_pos_reg[HORNER_N-1];
            for (int j = 0; j < DIV_N; j++) begin
                d_rem_reg[j] <= d_rout[j];
                d_quo_reg[j] <= d_quo[j];
                d_q_reg[j]   <= d_qin[j];
                d_pos_reg[j] <= d_posin[j];
            end
            for (int s = 0; s < SQ_N; s++) begin
                s_p_reg[s]   <= SQ_W'(s_r[s]) * SQ_W'(s_r[s]);
                s_pos_reg[s] <= (s == 0) ? d_pos_reg[DIV_N-1] : s_pos_reg[s-1];
            end
            phi_reg <= s_pos_reg[SQ_N-1] ? (ONE_Q30 - fin_half) : fin_half;
        end
    end

    assign phi_out = phi_reg;

endmodule

// ===== rtl/core/normal_cdf_approx.sv =====
// top level of the normal cdf pipeline: decode, standardizing divider, two phi lanes
// depends on ncdf_pkg and ncdf_phi
//
// Standard normal cdf, one request per clock unless the result side stalls. Each
// request returns exactly one result after it is taken, passing through two entry
// stages, a 20-stage restoring divider for (x - mean) / spread, one stage that
// forms the clamped |z|, 43 stages in each phi lane (six horner multiplies, a
// 31-stage reciprocal divider, four squarings) and the output register. The whole
// pipeline advances together whenever the output register is free or being
// taken, so s_tready drops only while m_tvalid is held by m_tready. Mean and
// spread are written through the cfg channel, which is always ready; writes must
// happen with the pipeline empty. Kind 3, or kind 1 with a spread that is not
// positive, returns probability 0 with m_tuser set.
module normal_cdf_approx (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ncdf_pkg::DATA_IN_W-1:0] s_tdata,   // value_a, value_b
    input  logic [ncdf_pkg::KIND_W-1:0]    s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ncdf_pkg::PROB_W-1:0]    m_tdata,   // probability
    output logic [0:0]                     m_tuser,   // bad_request
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ncdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ncdf_pkg::CFG_W-1:0]     cfg_data
);
    import ncdf_pkg::*;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic              bad;
    } meta_t;

    function automatic logic [T_W-1:0] clamp_mag(input logic [IN_W-1:0] mag);
        if (mag > IN_W'(T_MAX)) begin
            return T_MAX;
        end
        return mag[T_W-1:0];
    endfunction

    function automatic logic [IN_W-1:0] abs_val(input logic [IN_W-1:0] v);
        return v[IN_W-1] ? (IN_W'(0) - v) : v;
    endfunction

    logic [CFG_W-1:0] mean_reg;
    logic [CFG_W-1:0] spread_reg;
    logic             en;

    // entry stages
    meta_t             s0_meta_reg, s0_meta_next;
    logic [IN_W-1:0]   a0_reg, b0_reg;
    logic [DIFF_W-1:0] diff0_reg;

    meta_t                    s1_meta_reg;
    logic [IN_W-1:0]          a1_reg, b1_reg;
    logic                     neg1_reg, sat1_reg;
    logic [SPR_W-1:0]         rem1_reg;
    logic [STD_BITS-1:0]      low1_reg;
    logic [DIFF_W-1:0]        s1_nabs;
    logic [DIFF_W+FRAC_W-1:0] s1_num;
    logic                     s1_sat;

    // standardizing divider stages
    meta_t               dv_meta_reg [STD_BITS];
    logic [IN_W-1:0]     dv_a_reg    [STD_BITS];
    logic [IN_W-1:0]     dv_b_reg    [STD_BITS];
    logic                dv_neg_reg  [STD_BITS];
    logic                dv_sat_reg  [STD_BITS];
    logic [STD_BITS-1:0] dv_low_reg  [STD_BITS];
    logic [SPR_W-1:0]    dv_rem_reg  [STD_BITS];
    logic [STD_BITS-1:0] dv_quo_reg  [STD_BITS];
    logic [SPR_W-1:0]    dv_rin      [STD_BITS];
    logic [SPR_W:0]      dv_trial    [STD_BITS];
    logic                dv_ge       [STD_BITS];
    logic [SPR_W-1:0]    dv_rout     [STD_BITS];
    logic [STD_BITS-1:0] dv_quo      [STD_BITS];

    // |z| stage
    meta_t          z_meta_reg;
    logic [T_W-1:0] za_t_reg, zb_t_reg, za_t_next;
    logic           za_pos_reg, zb_pos_reg, za_pos_next;
    logic [IN_W-1:0] zl_a, zl_b;
    logic [STD_BITS-1:0] zl_quo;

    // phi lanes
    meta_t          ph_meta_reg [PHI_LAT];
    logic [R_W-1:0] pa, pb;

    // output register
    logic              m_tvalid_reg;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic              bad_reg;
    meta_t             last_meta;

    assign en        = !m_tvalid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_comb begin
        s0_meta_next.valid = s_tvalid;
        s0_meta_next.kind  = s_tuser;
        s0_meta_next.bad   = (s_tuser == KIND_RSVD) ||
                             ((s_tuser == KIND_SCALE) &&
                              (spread_reg[CFG_W-1] || (spread_reg == '0)));
    end

    always_comb begin
        s1_nabs = diff0_reg[DIFF_W-1] ? (DIFF_W'(0) - diff0_reg) : diff0_reg;
        s1_num  = {s1_nabs, FRAC_W'(0)};
        // quotient of 2^20 or more clamps anyway
        s1_sat  = (SPR_W'(s1_num[DIFF_W+FRAC_W-1:STD_BITS]) >= spread_reg[SPR_W-1:0]);
    end

    always_comb begin
        for (int j = 0; j < STD_BITS; j++) begin
            dv_rin[j]   = (j == 0) ? rem1_reg : dv_rem_reg[j-1];
            dv_trial[j] = (j == 0) ? {dv_rin[j], low1_reg[STD_BITS-1-j]}
                                   : {dv_rin[j], dv_low_reg[j-1][STD_BITS-1-j]};
            dv_ge[j]    = (dv_trial[j] >= {1'b0, spread_reg[SPR_W-1:0]});
            dv_rout[j]  = dv_ge[j] ? SPR_W'(dv_trial[j] - {1'b0, spread_reg[SPR_W-1:0]})
                                   : SPR_W'(dv_trial[j]);
            dv_quo[j]   = (j == 0) ? STD_BITS'(dv_ge[j])
                                   : {dv_quo_reg[j-1][STD_BITS-2:0], dv_ge[j]};
        end
    end

    always_comb begin
        zl_a   = dv_a_reg[STD_BITS-1];
        zl_b   = dv_b_reg[STD_BITS-1];
        zl_quo = dv_quo_reg[STD_BITS-1];
        if (dv_meta_reg[STD_BITS-1].kind == KIND_SCALE) begin
            za_t_next   = dv_sat_reg[STD_BITS-1] ? T_MAX : clamp_mag(IN_W'(zl_quo));
            za_pos_next = !dv_neg_reg[STD_BITS-1] &&
                          (dv_sat_reg[STD_BITS-1] || (zl_quo != '0));
        end else begin
            za_t_next   = clamp_mag(abs_val(zl_a));
            za_pos_next = !zl_a[IN_W-1] && (zl_a != '0);
        end
    end

    ncdf_phi u_phi_a (
        .aclk    (aclk),
        .en      (en),
        .t_in    (za_t_reg),
        .pos_in  (za_pos_reg),
        .phi_out (pa)
    );

    ncdf_phi u_phi_b (
        .aclk    (aclk),
        .en      (en),
        .t_in    (zb_t_reg),
        .pos_in  (zb_pos_reg),
        .phi_out (pb)
    );

    always_comb begin
        last_meta = ph_meta_reg[PHI_LAT-1];
        if (last_meta.bad) begin
            prob_next = '0;
        end else if (last_meta.kind == KIND_DIFF) begin
            prob_next = PROB_W'({1'b0, pb}) - PROB_W'({1'b0, pa});
        end else begin
            prob_next = PROB_W'({1'b0, pa});
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg     <= MEAN_RST;
            spread_reg   <= SPREAD_RST;
            m_tvalid_reg <= 1'b0;
            s0_meta_reg  <= '0;
            s1_meta_reg  <= '0;
            z_meta_reg   <= '0;
            for (int j = 0; j < STD_BITS; j++) begin
                dv_meta_reg[j] <= '0;
            end
            for (int p = 0; p < PHI_LAT; p++) begin
                ph_meta_reg[p] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MEAN:   mean_reg   <= cfg_data;
                    REG_SPREAD: spread_reg <= cfg_data;
                endcase
            end
            if (en) begin
                s0_meta_reg <= s0_meta_next;
                s1_meta_reg <= s0_meta_reg;
                for (int j = 0; j < STD_BITS; j++) begin
                    dv_meta_reg[j] <= (j == 0) ? s1_meta_reg : dv_meta_reg[j-1];
                end
                z_meta_reg <= dv_meta_reg[STD_BITS-1];
                for (int p = 0; p < PHI_LAT; p++) begin
                    ph_meta_reg[p] <= (p == 0) ? z_meta_reg : ph_meta_reg[p-1];
                end
                m_tvalid_reg <= last_meta.valid;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg    <= s_tdata[IN_W-1:0];
            b0_reg    <= s_tdata[DATA_IN_W-1:IN_W];
            diff0_reg <= {s_tdata[IN_W-1], s_tdata[IN_W-1:0]} - {mean_reg[CFG_W-1], mean_reg};

            a1_reg   <= a0_reg;
            b1_reg   <= b0_reg;
            neg1_reg <= diff0_reg[DIFF_W-1];
            sat1_reg <= s1_sat;
            rem1_reg <= SPR_W'(s1_num[DIFF_W+FRAC_W-1:STD_BITS]);
            low1_reg <= s1_num[STD_BITS-1:0];

            for (int j = 0; j < STD_BITS; j++) begin
                dv_a_reg[j]   <= (j == 0) ? a1_reg   : dv_a_reg[j-1];
                dv_b_reg[j]   <= (j == 0) ? b1_reg   : dv_b_reg[j-1];
                dv_neg_reg[j] <= (j == 0) ? neg1_reg : dv_neg_reg[j-1];
                dv_sat_reg[j] <= (j == 0) ? sat1_reg : dv_sat_reg[j-1];
                dv_low_reg[j] <= (j == 0) ? low1_reg : dv_low_reg[j-1];
                dv_rem_reg[j] <= dv_rout[j];
                dv_quo_reg[j] <= dv_quo[j];
            end

            za_t_reg   <= za_t_next;
            za_pos_reg <= za_pos_next;
            zb_t_reg   <= clamp_mag(abs_val(zl_b));
            zb_pos_reg <= !zl_b[IN_W-1] && (zl_b != '0);

            prob_reg <= prob_next;
            bad_reg  <= last_meta.bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = prob_reg;
    assign m_tuser  = bad_reg;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("flagged result carries a nonzero probability");

    a_prob_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata) <= 32'sh4000_0000) &&
                      ($signed(m_tdata) >= -32'sh4000_0000)))
        else $error("probability outside [-1, 1]");

    a_phi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ph_meta_reg[PHI_LAT-1].valid |-> ((pa <= ONE_Q30) && (pb <= ONE_Q30)))
        else $error("phi lane above 1.0");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// testbench for normal_cdf_approx: directed table plus random requests over several
// mean and spread settings, results checked against typed values or a phi predictor
// depends on ncdf_pkg and the normal_cdf_approx rtl
`timescale 1ns / 1ps

module tb;
    import ncdf_pkg::*;

    localparam longint ONE_P = 64'd1 << 30;
    localparam longint T_CLAMP = 64'd8 << 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT = 100;
    localparam int RAND_PER_PHASE = 200;

    typedef struct {
        logic [PROB_W-1:0] prob;
        logic              bad;
    } cdf_result_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [IN_W-1:0]   a;
        logic [IN_W-1:0]   b;
        bit                typed;
        logic [PROB_W-1:0] prob;
        logic              bad;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_IN_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PROB_W-1:0]    m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cdf_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    longint      mean_reg;
    longint      spread_reg;
    int          fail_count;
    int          cycle_count;
    bit          idle_on;

    normal_cdf_approx dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // phi(z) in Q30 for z in Q16
    function automatic longint phi_q30(longint z);
        longint unsigned t, acc, q, r, h;
        t = (z < 0) ? longint'(-z) : longint'(z);
        if (t > T_CLAMP) t = T_CLAMP;
        acc = COEF[5];
        for (int k = 4; k >= 0; k--)
            acc = COEF[k] + ((acc * t + 32768) >> 16);
        acc = (acc * t + 32768) >> 16;
        q = ONE_P + acc;
        r = ((64'd1 << 60) + (q >> 1)) / q;
        for (int k = 0; k < 4; k++)
            r = (r * r + (ONE_P >> 1)) >> 30;
        h = (r + 1) >> 1;
        return (z > 0) ? longint'(ONE_P - h) : longint'(h);
    endfunction

    function automatic cdf_result_t predict_cdf(logic [KIND_W-1:0] kind,
                                               logic [IN_W-1:0] a, logic [IN_W-1:0] b);
        cdf_result_t res;
        longint sa, sb, p;
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        p = 0;
        res.bad = 1'b0;
        case (kind)
            KIND_STD:   p = phi_q30(sa);
            KIND_SCALE: begin
                if (spread_reg > 0) p = phi_q30(((sa - mean_reg) * 65536) / spread_reg);
                else res.bad = 1'b1;
            end
            KIND_DIFF:  p = phi_q30(sb) - phi_q30(sa);
            default:    res.bad = 1'b1;
        endcase
        res.prob = p[PROB_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        cdf_result_t exp_res;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[normal_cdf_approx] ERROR");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: probability %h", m_tdata);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata !== exp_res.prob) begin
                    $error("probability: expected %h, got %h", exp_res.prob, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_res.bad) begin
                    $error("bad_request: expected %b, got %b", exp_res.bad, m_tuser[0]);
                    fail_count++;
                end
            end
        end
        m_tready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
    end

    // stop sending and wait until every queued result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_MEAN) mean_reg = longint'(signed'(val));
        else spread_reg = longint'(signed'(val));
    endtask

    task automatic set_params(logic [CFG_W-1:0] m, logic [CFG_W-1:0] s);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        write_reg(REG_MEAN, m);
        write_reg(REG_SPREAD, s);
        cfg_valid <= 1'b0;
    endtask

    // one request; expectation is queued at the accepting edge
    // tvalid stays up after the transaction until the next request or a drain
    task automatic send_req(stim_row_t row);
        cdf_result_t res;
        while (idle_on && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.kind;
        s_tdata  <= {row.b, row.a};
        do @(posedge aclk); while (!s_tready);
        if (row.typed) begin
            res.prob = row.prob;
            res.bad  = row.bad;
        end else begin
            res = predict_cdf(row.kind, row.a, row.b);
        end
        pending_results.push_back(res);
    endtask

    task automatic add_row(logic [KIND_W-1:0] k, logic [IN_W-1:0] a, logic [IN_W-1:0] b,
                           bit typed, logic [PROB_W-1:0] p, logic bad);
        stim_row_t row;
        row.kind = k;
        row.a = a;
        row.b = b;
        row.typed = typed;
        row.prob = p;
        row.bad = bad;
        directed_rows.push_back(row);
    endtask

    function automatic logic [IN_W-1:0] pick_value();
        // mostly scores within the interesting range, sometimes anything
        if ($urandom_range(99) < 70)
            return IN_W'(int'($urandom_range(1200000)) - 600000);
        return $urandom;
    endfunction

    task automatic random_burst(int count, bit with_pause);
        stim_row_t row;
        for (int i = 0; i < count; i++) begin
            if (with_pause && i == count / 2) wait_drained();
            row.kind  = ($urandom_range(99) < 6) ? KIND_RSVD : KIND_W'($urandom_range(2));
            row.a     = pick_value();
            row.b     = pick_value();
            row.typed = 1'b0;
            send_req(row);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_STD;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MEAN;
        cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        mean_reg = longint'(signed'(MEAN_RST));
        spread_reg = longint'(signed'(SPREAD_RST));
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: mean 0, spread 1.0
        add_row(KIND_STD,   32'h0000_0000, 32'h0, 1, 32'h2000_0000, 1'b0);
        add_row(KIND_STD,   32'h7fff_ffff, 32'h0, 1, 32'h4000_0000, 1'b0);
        add_row(KIND_STD,   32'h8000_0000, 32'h0, 1, 32'h0000_0000, 1'b0);
        add_row(KIND_STD,   32'h0008_0000, 32'h0, 0, '0, 1'b0);
        add_row(KIND_STD,   32'hfff8_0000, 32'h0, 0, '0, 1'b0);
        add_row(KIND_STD,   32'h0000_0001, 32'h0, 0, '0, 1'b0);
        add_row(KIND_STD,   32'hffff_ffff, 32'h0, 0, '0, 1'b0);
        add_row(KIND_STD,   32'h0001_0000, 32'h0, 0, '0, 1'b0);
        add_row(KIND_SCALE, 32'h0000_0000, 32'h0, 1, 32'h2000_0000, 1'b0);
        add_row(KIND_SCALE, 32'h7fff_ffff, 32'h0, 1, 32'h4000_0000, 1'b0);
        add_row(KIND_SCALE, 32'h8000_0000, 32'hffff_ffff, 1, 32'h0000_0000, 1'b0);
        add_row(KIND_SCALE, 32'hffff_0000, 32'h0, 0, '0, 1'b0);
        add_row(KIND_DIFF,  32'h8000_0000, 32'h7fff_ffff, 1, 32'h4000_0000, 1'b0);
        add_row(KIND_DIFF,  32'h7fff_ffff, 32'h8000_0000, 1, 32'hc000_0000, 1'b0);
        add_row(KIND_DIFF,  32'h1234_5678, 32'h1234_5678, 1, 32'h0000_0000, 1'b0);
        add_row(KIND_DIFF,  32'hffff_0000, 32'h0001_0000, 0, '0, 1'b0);
        add_row(KIND_RSVD,  32'h0000_0000, 32'h0, 1, 32'h0000_0000, 1'b1);
        add_row(KIND_RSVD,  32'hffff_ffff, 32'hffff_ffff, 1, 32'h0000_0000, 1'b1);
        foreach (directed_rows[i]) send_req(directed_rows[i]);
        random_burst(RAND_PER_PHASE, 1'b0);

        // extremes of the registers; spread of zero and below flags scaled requests
        set_params(32'h7fff_ffff, 32'h0000_0001);
        random_burst(RAND_PER_PHASE, 1'b1);
        set_params(32'h8000_0000, 32'h7fff_ffff);
        random_burst(RAND_PER_PHASE, 1'b0);
        set_params(32'h0001_e240, 32'h0000_0000);
        random_burst(RAND_PER_PHASE, 1'b0);
        idle_on = 1'b0;
        set_params(32'hffff_ec78, 32'h8000_0000);
        random_burst(RAND_PER_PHASE, 1'b0);
        idle_on = 1'b1;
        set_params($urandom, 32'h0003_0000);
        random_burst(RAND_PER_PHASE, 1'b0);
        set_params(32'h0000_0000, 32'h0000_8000);
        random_burst(RAND_PER_PHASE, 1'b0);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[normal_cdf_approx] OK");
        end else begin
            $display("[normal_cdf_approx] ERROR");
        end
        $finish;
    end

endmodule
